### hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock, off while reset is asserted
`define NBC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// implication form: condition this cycle, consequence next cycle
`define NBC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    `NBC_ASSERT(label, clk, rst_n, (cond) |=> (cons), msg)

`endif

### hw/rtl/nbc_pkg.sv
// shared types, sizes and codes of the ipv6 neighbor cache
// no dependencies; used by the top level and the checker
`timescale 1ns / 1ps

package nbc_pkg;

    // bucket count must be a power of two, at least two
    localparam int BUCKETS = 256;
    localparam int WAYS    = 4;
    localparam int ENTRIES = BUCKETS * WAYS;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WORD_W = 32;
    localparam int KEY_W  = 64;
    localparam int MAC_W  = 48;
    localparam int PORT_W = 4;
    localparam int ENT_W  = 2 * KEY_W + MAC_W + PORT_W;

    typedef enum logic [2:0] {
        STAT_UPDATED  = 3'd0,
        STAT_INSERTED = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_HIT      = 3'd3,
        STAT_MISS     = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        FUNC_UPDATE = 1'b0,
        FUNC_SEARCH = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } t_entry;

    // sum of the four 32-bit words, reduced to a bucket number
    function automatic logic [BKT_W-1:0] hash_bucket(
        input logic [KEY_W-1:0] hi,
        input logic [KEY_W-1:0] lo
    );
        logic [WORD_W-1:0] sum;
        sum = hi[KEY_W-1:WORD_W] + hi[WORD_W-1:0] + lo[KEY_W-1:WORD_W] + lo[WORD_W-1:0];
        return sum[BKT_W-1:0];
    endfunction

endpackage

### hw/rtl/nbc_ram.sv
// simple dual-port ram: one write port, one registered read port
// no dependencies; used twice by the neighbor cache top level
`timescale 1ns / 1ps

module nbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ipv6_neighbor_cache_top.sv
// hashed ipv6 neighbor cache: update/insert and search over bucketed ways
// depends on nbc_pkg and nbc_ram (entry store and per-bucket valid rows)
`timescale 1ns / 1ps

// The cache holds BUCKETS buckets of WAYS entries, each keyed by a full
// 128-bit ipv6 address and holding a 48-bit link address and a 4-bit port.
// A beat picks its bucket from the 32-bit sum of the four address words,
// low bits only. An update rewrites a matching entry, else takes the lowest
// free way, else reports bucket full and is dropped. A search reports hit
// with the stored link address and port, or miss with zeros. One item
// occupies the block from accept to the next possible accept, through these
// steps in order: the hash state starts the bucket read; the compare state
// takes one way at a time, up to a match or the last way, through the single
// 128-bit key comparator fed by the one read port of the entry ram, while
// the next way is fetched; the done state writes back and loads the result
// register; and the idle state takes the next beat, so no beat is taken
// before the last one is written back. The write-back state stretches for as
// long as the previous result still waits on i_stall. After reset a clearing
// pass over every bucket zeroes the valid rows, and o_stall stays high
// meanwhile. The result register lets a finished beat wait on i_stall
// while the next item is accepted and worked on.
module ipv6_neighbor_cache_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_func,
    input  logic [nbc_pkg::KEY_W-1:0]  i_addr_high,
    input  logic [nbc_pkg::KEY_W-1:0]  i_addr_low,
    input  logic [nbc_pkg::MAC_W-1:0]  i_mac_address,
    input  logic [nbc_pkg::PORT_W-1:0] i_device_port,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_status,
    output logic [nbc_pkg::MAC_W-1:0]  o_found_mac,
    output logic [nbc_pkg::PORT_W-1:0] o_found_port
);

    localparam int BKT_W  = nbc_pkg::BKT_W;
    localparam int WAY_W  = nbc_pkg::WAY_W;
    localparam int IDX_W  = nbc_pkg::IDX_W;
    localparam int WAYS   = nbc_pkg::WAYS;

    // flat entry index of way w in bucket b
    function automatic logic [IDX_W-1:0] entry_index(
        input logic [BKT_W-1:0] b,
        input logic [WAY_W-1:0] w
    );
        return IDX_W'(IDX_W'(b) * IDX_W'(WAYS)) + IDX_W'(w);
    endfunction

    // sequencer and control state
    nbc_pkg::t_state r_state, n_state;
    logic [WAY_W-1:0] r_way;
    logic [BKT_W-1:0] r_clr_cnt;
    logic             r_hit;
    logic             r_o_valid;

    // captured request
    nbc_pkg::t_func              r_func;
    logic [nbc_pkg::KEY_W-1:0]   r_key_high;
    logic [nbc_pkg::KEY_W-1:0]   r_key_low;
    logic [nbc_pkg::MAC_W-1:0]   r_mac;
    logic [nbc_pkg::PORT_W-1:0]  r_port;
    logic [BKT_W-1:0]            r_bucket;

    // hit capture
    logic [WAY_W-1:0]            r_hit_way;
    logic [nbc_pkg::MAC_W-1:0]   r_hit_mac;
    logic [nbc_pkg::PORT_W-1:0]  r_hit_port;

    // result register
    nbc_pkg::t_status            r_o_status;
    logic [nbc_pkg::MAC_W-1:0]   r_o_mac;
    logic [nbc_pkg::PORT_W-1:0]  r_o_port;

    // ram ports
    nbc_pkg::t_entry  ent_rd;
    nbc_pkg::t_entry  ent_wd;
    logic             ent_we;
    logic [IDX_W-1:0] ent_waddr;
    logic [IDX_W-1:0] ent_raddr;
    logic [WAYS-1:0]  vld_row;
    logic [WAYS-1:0]  vld_wdata;
    logic             vld_we;
    logic [BKT_W-1:0] vld_waddr;
    logic [BKT_W-1:0] vld_raddr;

    // datapath terms
    logic             in_accept;
    logic             out_free;
    logic             way_hit;
    logic             last_way;
    logic             free_any;
    logic [WAY_W-1:0] free_way;
    logic             do_write;
    logic             do_insert;
    nbc_pkg::t_status res_status;
    logic [BKT_W-1:0] hash_bkt;

    assign in_accept = (r_state == nbc_pkg::S_IDLE) && i_valid;
    assign out_free  = !r_o_valid || !i_stall;
    assign hash_bkt  = nbc_pkg::hash_bucket(r_key_high, r_key_low);

    // the one shared comparator: current way against the captured key
    assign way_hit  = vld_row[r_way] && (ent_rd.key_high == r_key_high)
                      && (ent_rd.key_low == r_key_low);
    assign last_way = (r_way == WAY_W'(WAYS - 1));

    // lowest free way of the bucket row
    always_comb begin
        free_any = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!vld_row[w]) begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    // result code of the finished lookup
    always_comb begin
        if (r_func == nbc_pkg::FUNC_SEARCH) begin
            res_status = r_hit ? nbc_pkg::STAT_HIT : nbc_pkg::STAT_MISS;
        end else if (r_hit) begin
            res_status = nbc_pkg::STAT_UPDATED;
        end else if (free_any) begin
            res_status = nbc_pkg::STAT_INSERTED;
        end else begin
            res_status = nbc_pkg::STAT_FULL;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nbc_pkg::S_CLEAR: begin
                if (r_clr_cnt == BKT_W'(nbc_pkg::BUCKETS - 1)) begin
                    n_state = nbc_pkg::S_IDLE;
                end
            end
            nbc_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = nbc_pkg::S_HASH;
                end
            end
            nbc_pkg::S_HASH: begin
                n_state = nbc_pkg::S_CMP;
            end
            nbc_pkg::S_CMP: begin
                if (way_hit || last_way) begin
                    n_state = nbc_pkg::S_DONE;
                end
            end
            nbc_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = nbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nbc_pkg::S_CLEAR;
            end
        endcase
    end

    // sequencer outputs: handshake, ram addresses and write strobes
    always_comb begin
        o_stall   = 1'b1;
        do_write  = 1'b0;
        do_insert = 1'b0;
        ent_raddr = entry_index(r_bucket, r_way + WAY_W'(1));
        vld_raddr = r_bucket;
        vld_we    = 1'b0;
        vld_waddr = r_bucket;
        vld_wdata = vld_row;
        case (r_state)
            nbc_pkg::S_CLEAR: begin
                vld_we    = 1'b1;
                vld_waddr = r_clr_cnt;
                vld_wdata = '0;
            end
            nbc_pkg::S_IDLE: begin
                o_stall = 1'b0;
            end
            nbc_pkg::S_HASH: begin
                ent_raddr = entry_index(hash_bkt, '0);
                vld_raddr = hash_bkt;
            end
            nbc_pkg::S_CMP: begin
                // next way is fetched while this one is compared
            end
            nbc_pkg::S_DONE: begin
                if (out_free && (r_func == nbc_pkg::FUNC_UPDATE)) begin
                    do_write  = r_hit || free_any;
                    do_insert = !r_hit && free_any;
                end
                vld_we    = do_insert;
                vld_wdata = vld_row | (WAYS'(1) << free_way);
            end
            default: begin
            end
        endcase
    end

    assign ent_we    = do_write;
    assign ent_waddr = entry_index(r_bucket, r_hit ? r_hit_way : free_way);
    assign ent_wd    = '{key_high: r_key_high, key_low: r_key_low,
                         mac: r_mac, port: r_port};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nbc_pkg::S_CLEAR;
            r_way     <= '0;
            r_clr_cnt <= '0;
            r_hit     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == nbc_pkg::S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + BKT_W'(1);
            end
            if (r_state == nbc_pkg::S_HASH) begin
                r_way <= '0;
                r_hit <= 1'b0;
            end else if (r_state == nbc_pkg::S_CMP) begin
                if (way_hit) begin
                    r_hit <= 1'b1;
                end else if (!last_way) begin
                    r_way <= r_way + WAY_W'(1);
                end
            end
            if ((r_state == nbc_pkg::S_DONE) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func     <= nbc_pkg::t_func'(i_func);
            r_key_high <= i_addr_high;
            r_key_low  <= i_addr_low;
            r_mac      <= i_mac_address;
            r_port     <= i_device_port;
        end
        if (r_state == nbc_pkg::S_HASH) begin
            r_bucket <= hash_bkt;
        end
        if ((r_state == nbc_pkg::S_CMP) && way_hit) begin
            r_hit_way  <= r_way;
            r_hit_mac  <= ent_rd.mac;
            r_hit_port <= ent_rd.port;
        end
        if ((r_state == nbc_pkg::S_DONE) && out_free) begin
            r_o_status <= res_status;
            if (res_status == nbc_pkg::STAT_HIT) begin
                r_o_mac  <= r_hit_mac;
                r_o_port <= r_hit_port;
            end else begin
                r_o_mac  <= '0;
                r_o_port <= '0;
            end
        end
    end

    // entry store: key, link address and port per way
    nbc_ram #(
        .WIDTH (nbc_pkg::ENT_W),
        .DEPTH (nbc_pkg::ENTRIES),
        .AW    (IDX_W)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wd),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rd)
    );

    // valid rows, one row of way bits per bucket
    nbc_ram #(
        .WIDTH (WAYS),
        .DEPTH (nbc_pkg::BUCKETS),
        .AW    (BKT_W)
    ) u_vld_ram (
        .i_clk   (i_clk),
        .i_we    (vld_we),
        .i_waddr (vld_waddr),
        .i_wdata (vld_wdata),
        .i_raddr (vld_raddr),
        .o_rdata (vld_row)
    );

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_found_mac  = r_o_mac;
    assign o_found_port = r_o_port;

endmodule

### hw/rtl/nbc_checker.sv
// port-level checker for the ipv6 neighbor cache, bound to the top level
// depends on nbc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nbc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       i_func,
    input logic [nbc_pkg::KEY_W-1:0]  i_addr_high,
    input logic [nbc_pkg::KEY_W-1:0]  i_addr_low,
    input logic [nbc_pkg::MAC_W-1:0]  i_mac_address,
    input logic [nbc_pkg::PORT_W-1:0] i_device_port,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [2:0]                 o_status,
    input logic [nbc_pkg::MAC_W-1:0]  o_found_mac,
    input logic [nbc_pkg::PORT_W-1:0] o_found_port
);

    logic in_beat;
    logic out_held;

    assign in_beat  = i_valid && !o_stall;
    assign out_held = o_valid && i_stall;

    // a stalled result beat stays up with the same payload
    `NBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_valid && $stable(o_status) && $stable(o_found_mac) && $stable(o_found_port), "result beat changed while stalled")

    // the block is busy in the cycle after it takes a request
    `NBC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_beat, o_stall, "request taken while lookup in progress")

    // link address and port are zero unless the beat is a search hit
    `NBC_ASSERT(a_zero_unless_hit, i_clk, i_rst_n, (o_valid && (o_status != nbc_pkg::STAT_HIT)) |-> ((o_found_mac == '0) && (o_found_port == '0)), "nonzero payload on a result that is not a hit")

    // only the five defined result codes appear
    `NBC_ASSERT(a_status_code, i_clk, i_rst_n, o_valid |-> (o_status <= 3'(nbc_pkg::STAT_MISS)), "undefined result code")

endmodule

bind ipv6_neighbor_cache_top nbc_checker u_nbc_checker (.*);
